FILE: rtl/core/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder core.
// Holds the request, response and internal job types. No dependencies.
package u8u16_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_end;
      logic        string_end;
   } rsp_type;

   // One decoded input byte: a run of replacement units followed by up to two
   // real code units.
   typedef struct packed {
      logic [2:0]  repl_cnt;
      logic [1:0]  tail_cnt;
      logic [15:0] tail_hi;
      logic [15:0] tail_lo;
      logic        fin;
   } job_type;

   localparam logic [2:0]  LEN_BAD   = 3'd0;
   localparam logic [2:0]  LEN_ONE   = 3'd1;
   localparam logic [2:0]  LEN_TWO   = 3'd2;
   localparam logic [2:0]  LEN_THREE = 3'd3;
   localparam logic [2:0]  LEN_FOUR  = 3'd4;

   localparam logic [15:0] REPL_UNIT     = 16'hFFFD;
   localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
   localparam logic [20:0] PLANE1_BASE   = 21'h10000;
   localparam logic [20:0] CP_MAX        = 21'h10FFFF;
   localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
   localparam logic [20:0] MIN_TWO       = 21'h000080;
   localparam logic [20:0] MIN_THREE     = 21'h000800;
   localparam logic [20:0] SURR_LOW      = 21'h00D800;
   localparam logic [20:0] SURR_HIGH     = 21'h00DFFF;

   function automatic logic [2:0] seq_len(input logic [7:0] lead);
      logic [2:0] len;
      len = LEN_BAD;
      if (lead[7] == 1'b0) begin
         len = LEN_ONE;
      end else if (lead[7:5] == 3'b110) begin
         len = LEN_TWO;
      end else if (lead[7:4] == 4'b1110) begin
         len = LEN_THREE;
      end else if (lead[7:3] == 5'b11110) begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

endpackage

FILE: rtl/core/u8u16_front.sv
// Front end: accepts bytes, keeps the pending sequence and classifies each
// byte into at most one job. Depends on u8u16_pkg.
module u8u16_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  u8u16_pkg::req_type req_data,
   output logic               push_valid,
   output u8u16_pkg::job_type push_job,
   input  logic               queue_full
);
   import u8u16_pkg::*;

   logic [1:0]  count_ff, count_in;
   logic [7:0]  pend_ff [3];
   logic [7:0]  pend_in [3];
   logic        accept;
   logic [7:0]  b;
   logic        fin;
   logic        is_cont;
   logic [2:0]  need_b, need_l;
   logic [2:0]  p_plus;
   logic [2:0]  solo_repl;
   logic [1:0]  solo_tail;
   logic        solo_pend;
   logic [20:0] cp;
   logic [20:0] v;
   logic        cp_bad;
   job_type     job;

   assign b         = req_data.data_byte;
   assign fin       = req_data.final_byte;
   assign is_cont   = (b[7:6] == 2'b10);
   assign need_b    = seq_len(b);
   assign need_l    = seq_len(pend_ff[0]);
   assign p_plus    = {1'b0, count_ff} + 3'd1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      solo_repl = 3'd0;
      solo_tail = 2'd0;
      solo_pend = 1'b0;
      unique case (need_b)
         LEN_ONE: solo_tail = 2'd1;
         LEN_BAD: solo_repl = 3'd1;
         default: begin
            if (fin) begin
               solo_repl = 3'd1;
            end else begin
               solo_pend = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      cp     = '0;
      cp_bad = 1'b0;
      unique case (need_l)
         LEN_TWO: begin
            cp     = {10'd0, pend_ff[0][4:0], b[5:0]};
            cp_bad = cp < MIN_TWO;
         end
         LEN_THREE: begin
            cp     = {5'd0, pend_ff[0][3:0], pend_ff[1][5:0], b[5:0]};
            cp_bad = (cp < MIN_THREE) || ((cp >= SURR_LOW) && (cp <= SURR_HIGH));
         end
         default: begin
            cp     = {pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0], b[5:0]};
            cp_bad = (cp < PLANE1_BASE) || (cp > CP_MAX);
         end
      endcase
      v = cp - PLANE1_BASE;
   end

   always_comb begin
      job          = '0;
      job.fin      = fin;
      job.tail_hi  = {8'd0, b};
      count_in     = count_ff;
      pend_in[0]   = pend_ff[0];
      pend_in[1]   = pend_ff[1];
      pend_in[2]   = pend_ff[2];
      if (count_ff == 2'd0) begin
         job.repl_cnt = solo_repl;
         job.tail_cnt = solo_tail;
         if (solo_pend) begin
            count_in   = 2'd1;
            pend_in[0] = b;
         end
      end else if (!is_cont) begin
         job.repl_cnt = {1'b0, count_ff} + solo_repl;
         job.tail_cnt = solo_tail;
         count_in     = {1'b0, solo_pend};
         if (solo_pend) begin
            pend_in[0] = b;
         end
      end else if (p_plus < need_l) begin
         if (fin) begin
            job.repl_cnt = p_plus;
            count_in     = 2'd0;
         end else begin
            pend_in[count_ff] = b;
            count_in          = p_plus[1:0];
         end
      end else begin
         count_in = 2'd0;
         if (cp_bad) begin
            job.repl_cnt = need_l;
         end else if (cp <= BMP_MAX) begin
            job.tail_cnt = 2'd1;
            job.tail_hi  = cp[15:0];
         end else begin
            job.tail_cnt = 2'd2;
            job.tail_hi  = HI_SURR_BASE | {6'd0, v[19:10]};
            job.tail_lo  = LO_SURR_BASE | {6'd0, v[9:0]};
         end
      end
   end

   assign push_job   = job;
   assign push_valid = accept && ((job.repl_cnt != 3'd0) || (job.tail_cnt != 2'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff[0] <= pend_in[0];
         pend_ff[1] <= pend_in[1];
         pend_ff[2] <= pend_in[2];
      end
   end

endmodule

FILE: rtl/core/u8u16_queue.sv
// Job queue between the front and back ends, a small circular buffer.
// Depends on u8u16_pkg.
module u8u16_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8u16_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output u8u16_pkg::job_type head_job
);
   import u8u16_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign head_job  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/u8u16_back.sv
// Back end: takes jobs from the queue and sends their code units one per
// transaction, flagging the last unit of each byte and string. Depends on u8u16_pkg.
module u8u16_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  u8u16_pkg::job_type job_head,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u8u16_pkg::rsp_type rsp_data
);
   import u8u16_pkg::*;

   logic       busy_ff, busy_in;
   logic [2:0] pos_ff, pos_in;
   job_type    job_ff;
   logic [2:0] total;
   logic       last;
   logic       rsp_acc;
   logic       load;

   assign total     = job_ff.repl_cnt + {1'b0, job_ff.tail_cnt};
   assign last      = (pos_ff == total - 3'd1);
   assign rsp_valid = busy_ff;
   assign rsp_acc   = busy_ff && rsp_ready;
   assign load      = job_valid && (!busy_ff || (rsp_acc && last));
   assign job_pop   = load;

   always_comb begin
      if (pos_ff < job_ff.repl_cnt) begin
         rsp_data.code_unit = REPL_UNIT;
      end else if (pos_ff == job_ff.repl_cnt) begin
         rsp_data.code_unit = job_ff.tail_hi;
      end else begin
         rsp_data.code_unit = job_ff.tail_lo;
      end
      rsp_data.run_end    = last;
      rsp_data.string_end = last && job_ff.fin;
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = 3'd0;
      end else if (rsp_acc) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_head;
      end
   end

endmodule

FILE: rtl/core/utf8_to_utf16_transcoder_core.sv
// Top level of the UTF-8 to UTF-16 transcoder core.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
// One UTF-8 byte is taken per req transaction and zero to four UTF-16 code
// units leave as rsp transactions. Invalid input yields one U+FFFD for each
// byte of the broken sequence, and a byte that breaks off a pending sequence
// is decoded on its own. The front end takes one byte per cycle as long as the
// job queue of QUEUE_DEPTH entries has room; the back end sends one code unit
// per cycle while rsp_ready is high; input stalls only once the queue fills.
// Each job goes through the queue and then the back end's job register.
module utf8_to_utf16_transcoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  u8u16_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u8u16_pkg::rsp_type rsp_data
);
   import u8u16_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    job_pop;
   logic    job_valid;
   job_type job_head;

   u8u16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head_job  (job_head)
   );

   u8u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
